/* hdl/column_rle_bitmap_decoder_assert.svh */
`ifndef COLUMN_RLE_BITMAP_DECODER_ASSERT_SVH
`define COLUMN_RLE_BITMAP_DECODER_ASSERT_SVH

// Checks that a condition implies a consequence in the same cycle.
`define CRBD_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define CRBD_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/crbd_pkg.sv */
`timescale 1ns / 1ps

package crbd_pkg;

    localparam int OFS_W       = 13;
    localparam int CFG_INDEX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_ROWS  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INTERLEAVED  = 2'd2;

    localparam logic [5:0] COLUMN_COUNT_RST = 6'd40;
    localparam logic [7:0] COLUMN_ROWS_RST  = 8'd200;
    localparam logic       INTERLEAVED_RST  = 1'b0;
    localparam logic [7:0] MIN_ROWS         = 8'd8;

    // Result kinds.
    localparam logic [1:0] KIND_SEGMENT = 2'd0;
    localparam logic [1:0] KIND_FINISH  = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    typedef struct packed {
        logic       op;
        logic [7:0] stream_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic             plane;
        logic [OFS_W-1:0] start_offset;
        logic [7:0]       write_count;
        logic [7:0]       fill_value;
        logic             last;
    } out_item_t;

    typedef struct packed {
        logic       load_in;
        logic       load_count;
        logic       lit;
        logic       load_run_byte;
        logic       next_pass;
        logic       emit;
        logic [1:0] kind;
        logic       seg_run;
        logic       last;
        logic       restart;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic op_end;
        logic byte_zero;
        logic rem_zero;
        logic rem_one;
        logic rem_le_rows;
        logic rows_one;
        logic rows_le_rem;
        logic cols_one;
        logic is_lit;
        logic b_pass_next;
    } status_t;

endpackage

/* hdl/crbd_datapath.sv */
`timescale 1ns / 1ps
`include "column_rle_bitmap_decoder_assert.svh"

module crbd_datapath
    import crbd_pkg::*;
#(
    parameter int ROW_STRIDE  = 40,
    parameter int PLANE_BYTES = 8000
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data,
    input  in_item_t               stream_item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output out_item_t              result_item,
    input  cmd_t                   cmd,
    output status_t                status
);

    localparam int ROWS_LIM_INT =
        (PLANE_BYTES / ROW_STRIDE > 255) ? 255 : PLANE_BYTES / ROW_STRIDE;
    localparam logic [7:0] ROWS_LIM = 8'(ROWS_LIM_INT);
    localparam logic [5:0] COLS_LIM = 6'((ROW_STRIDE > 63) ? 63 : ROW_STRIDE);
    localparam logic [OFS_W-1:0] STRIDE = OFS_W'(ROW_STRIDE);

    function automatic logic [7:0] eff_rows(input logic [7:0] r);
        logic [7:0] v;
        v = r;
        if (v > ROWS_LIM)
        begin
            v = ROWS_LIM;
        end
        if (v < MIN_ROWS)
        begin
            v = MIN_ROWS;
        end
        return v;
    endfunction

    function automatic logic [5:0] eff_cols(input logic [5:0] c);
        logic [5:0] v;
        v = c;
        if (v == 6'd0)
        begin
            v = 6'd1;
        end
        if (v > COLS_LIM)
        begin
            v = COLS_LIM;
        end
        return v;
    endfunction

    localparam logic [7:0] ROWS_RST = eff_rows(COLUMN_ROWS_RST);
    localparam logic [5:0] COLS_RST = eff_cols(COLUMN_COUNT_RST);

    logic             in_op_reg, in_op_next;
    logic [7:0]       in_byte_reg, in_byte_next;
    logic [7:0]       remaining_reg, remaining_next;
    logic             is_lit_reg, is_lit_next;
    logic [7:0]       run_byte_reg, run_byte_next;
    logic [7:0]       rows_left_reg, rows_left_next;
    logic [5:0]       column_base_reg, column_base_next;
    logic [OFS_W-1:0] write_offset_reg, write_offset_next;
    logic             plane_reg, plane_next;
    logic [5:0]       columns_left_reg, columns_left_next;
    logic             at_start_reg, at_start_next;
    logic [5:0]       column_count_reg, column_count_next;
    logic [7:0]       column_rows_reg, column_rows_next;
    logic             interleaved_reg, interleaved_next;
    logic             result_valid_reg, result_valid_next;
    out_item_t        result_item_reg, result_item_next;

    logic             seg_do;
    logic [7:0]       cnt;
    logic [7:0]       fill;
    logic [7:0]       rows_after;
    logic [5:0]       base_inc;
    logic [OFS_W-1:0] step;

    assign seg_do     = cmd.emit && (cmd.kind == KIND_SEGMENT);
    assign cnt        = cmd.seg_run ?
                        ((remaining_reg < rows_left_reg) ? remaining_reg : rows_left_reg) :
                        8'd1;
    assign fill       = cmd.seg_run ? run_byte_reg : in_byte_reg;
    assign rows_after = rows_left_reg - cnt;
    assign base_inc   = column_base_reg + 6'd1;
    assign step       = OFS_W'(cnt) * STRIDE;

    always_comb
    begin
        in_op_next        = in_op_reg;
        in_byte_next      = in_byte_reg;
        remaining_next    = remaining_reg;
        is_lit_next       = is_lit_reg;
        run_byte_next     = run_byte_reg;
        rows_left_next    = rows_left_reg;
        column_base_next  = column_base_reg;
        write_offset_next = write_offset_reg;
        plane_next        = plane_reg;
        columns_left_next = columns_left_reg;
        at_start_next     = at_start_reg;
        column_count_next = column_count_reg;
        column_rows_next  = column_rows_reg;
        interleaved_next  = interleaved_reg;
        result_item_next  = result_item_reg;
        result_valid_next = result_valid_reg && result_stall;

        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_COLUMN_COUNT: column_count_next = cfg_data[5:0];
                REG_COLUMN_ROWS:  column_rows_next  = cfg_data;
                REG_INTERLEAVED:  interleaved_next  = cfg_data[0];
                default:          ;
            endcase
            // Before the first byte of an image the counters follow the registers.
            if (at_start_reg &&
                (cfg_index == REG_COLUMN_COUNT || cfg_index == REG_COLUMN_ROWS ||
                 cfg_index == REG_INTERLEAVED))
            begin
                rows_left_next    = eff_rows(column_rows_next);
                columns_left_next = eff_cols(column_count_next);
            end
        end

        if (cmd.load_in)
        begin
            in_op_next   = stream_item.op;
            in_byte_next = stream_item.stream_byte;
            if (!stream_item.op)
            begin
                at_start_next = 1'b0;
            end
        end

        if (cmd.load_count)
        begin
            remaining_next = in_byte_reg;
            is_lit_next    = cmd.lit;
        end

        if (cmd.load_run_byte)
        begin
            run_byte_next = in_byte_reg;
        end

        if (cmd.next_pass)
        begin
            plane_next        = 1'b1;
            column_base_next  = 6'd0;
            write_offset_next = '0;
            columns_left_next = eff_cols(column_count_reg);
        end

        if (cmd.emit)
        begin
            result_valid_next             = 1'b1;
            result_item_next              = '0;
            result_item_next.kind         = cmd.kind;
            result_item_next.last         = cmd.last;
            if (seg_do)
            begin
                result_item_next.plane        = plane_reg;
                result_item_next.start_offset = write_offset_reg;
                result_item_next.write_count  = cnt;
                result_item_next.fill_value   = fill;
            end
        end

        if (seg_do)
        begin
            remaining_next = remaining_reg - cnt;
            if (rows_after == 8'd0)
            begin
                // Column done: move to the next column, or the other plane.
                rows_left_next    = eff_rows(column_rows_reg);
                columns_left_next = columns_left_reg - 6'd1;
                if (interleaved_reg && !plane_reg)
                begin
                    plane_next        = 1'b1;
                    write_offset_next = OFS_W'(column_base_reg);
                end
                else
                begin
                    plane_next        = interleaved_reg ? 1'b0 : plane_reg;
                    column_base_next  = base_inc;
                    write_offset_next = OFS_W'(base_inc);
                end
            end
            else
            begin
                rows_left_next    = rows_after;
                write_offset_next = write_offset_reg + step;
            end
        end

        if (cmd.restart)
        begin
            remaining_next    = 8'd0;
            is_lit_next       = 1'b0;
            run_byte_next     = 8'd0;
            rows_left_next    = eff_rows(column_rows_reg);
            column_base_next  = 6'd0;
            write_offset_next = '0;
            plane_next        = 1'b0;
            columns_left_next = eff_cols(column_count_reg);
            at_start_next     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg    <= 8'd0;
            is_lit_reg       <= 1'b0;
            run_byte_reg     <= 8'd0;
            rows_left_reg    <= ROWS_RST;
            column_base_reg  <= 6'd0;
            write_offset_reg <= '0;
            plane_reg        <= 1'b0;
            columns_left_reg <= COLS_RST;
            at_start_reg     <= 1'b1;
            column_count_reg <= COLUMN_COUNT_RST;
            column_rows_reg  <= COLUMN_ROWS_RST;
            interleaved_reg  <= INTERLEAVED_RST;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            remaining_reg    <= remaining_next;
            is_lit_reg       <= is_lit_next;
            run_byte_reg     <= run_byte_next;
            rows_left_reg    <= rows_left_next;
            column_base_reg  <= column_base_next;
            write_offset_reg <= write_offset_next;
            plane_reg        <= plane_next;
            columns_left_reg <= columns_left_next;
            at_start_reg     <= at_start_next;
            column_count_reg <= column_count_next;
            column_rows_reg  <= column_rows_next;
            interleaved_reg  <= interleaved_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_op_reg       <= in_op_next;
        in_byte_reg     <= in_byte_next;
        result_item_reg <= result_item_next;
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_item_reg;

    assign status.out_free    = !result_valid_reg || !result_stall;
    assign status.op_end      = in_op_reg;
    assign status.byte_zero   = (in_byte_reg == 8'd0);
    assign status.rem_zero    = (remaining_reg == 8'd0);
    assign status.rem_one     = (remaining_reg == 8'd1);
    assign status.rem_le_rows = (remaining_reg <= rows_left_reg);
    assign status.rows_one    = (rows_left_reg == 8'd1);
    assign status.rows_le_rem = (rows_left_reg <= remaining_reg);
    assign status.cols_one    = (columns_left_reg == 6'd1);
    assign status.is_lit      = is_lit_reg;
    assign status.b_pass_next = !interleaved_reg && !plane_reg;

    `CRBD_ASSERT_IMPLY(a_rows_nonzero, clk, rst_n, 1'b1, rows_left_reg != 8'd0,
        "row counter reached zero without a column change")
    `CRBD_ASSERT_IMPLY(a_seg_count, clk, rst_n, seg_do, cnt != 8'd0,
        "write segment with zero count")
    `CRBD_ASSERT_IMPLY(a_start_origin, clk, rst_n, at_start_reg,
        column_base_reg == 6'd0 && !plane_reg && write_offset_reg == '0,
        "image start state with a moved write position")

endmodule

/* hdl/crbd_ctrl.sv */
`timescale 1ns / 1ps
`include "column_rle_bitmap_decoder_assert.svh"

module crbd_ctrl
    import crbd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    stream_valid,
    output logic    stream_stall,
    output cmd_t    cmd,
    input  status_t status
);

    localparam logic [1:0] ST_WAIT = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    localparam logic [2:0] PH_CODE    = 3'd0;
    localparam logic [2:0] PH_COUNT   = 3'd1;
    localparam logic [2:0] PH_VALUE   = 3'd2;
    localparam logic [2:0] PH_LITERAL = 3'd3;
    localparam logic [2:0] PH_CLOSE0  = 3'd4;
    localparam logic [2:0] PH_CLOSE1  = 3'd5;

    logic [1:0] state_reg, state_next;
    logic [2:0] phase_reg, phase_next;

    logic lit_pass_end;
    logic run_pass_end;

    assign lit_pass_end = status.rows_one && status.cols_one;
    assign run_pass_end = status.rows_le_rem && status.cols_one;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        phase_next = phase_reg;

        unique case (state_reg)
            ST_WAIT:
            begin
                if (stream_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                if (status.op_end)
                begin
                    if (status.out_free)
                    begin
                        cmd.emit    = 1'b1;
                        cmd.kind    = KIND_ERROR;
                        cmd.last    = 1'b1;
                        cmd.restart = 1'b1;
                        phase_next  = PH_CODE;
                        state_next  = ST_WAIT;
                    end
                end
                else
                begin
                    unique case (phase_reg)
                        PH_CODE:
                        begin
                            if (status.byte_zero)
                            begin
                                phase_next = PH_COUNT;
                            end
                            else
                            begin
                                cmd.load_count = 1'b1;
                                phase_next     = PH_VALUE;
                            end
                            state_next = ST_WAIT;
                        end

                        PH_COUNT:
                        begin
                            if (!status.byte_zero)
                            begin
                                cmd.load_count = 1'b1;
                                cmd.lit        = 1'b1;
                                phase_next     = PH_LITERAL;
                                state_next     = ST_WAIT;
                            end
                            else if (status.out_free)
                            begin
                                cmd.emit    = 1'b1;
                                cmd.kind    = KIND_FINISH;
                                cmd.last    = 1'b1;
                                cmd.restart = 1'b1;
                                phase_next  = PH_CODE;
                                state_next  = ST_WAIT;
                            end
                        end

                        PH_VALUE:
                        begin
                            cmd.load_run_byte = 1'b1;
                            phase_next        = PH_CODE;
                            state_next        = ST_RUN;
                        end

                        PH_LITERAL:
                        begin
                            if (status.out_free)
                            begin
                                cmd.emit    = 1'b1;
                                cmd.kind    = KIND_SEGMENT;
                                cmd.last    = 1'b1;
                                state_next  = ST_WAIT;
                                if (lit_pass_end)
                                begin
                                    phase_next = PH_CLOSE0;
                                end
                                else if (status.rem_one)
                                begin
                                    phase_next = PH_CODE;
                                end
                            end
                        end

                        PH_CLOSE0, PH_CLOSE1:
                        begin
                            if (!status.byte_zero || !status.b_pass_next ||
                                phase_reg == PH_CLOSE0)
                            begin
                                if (!status.byte_zero || !status.b_pass_next)
                                begin
                                    if (phase_reg == PH_CLOSE0 && status.byte_zero)
                                    begin
                                        phase_next = PH_CLOSE1;
                                        state_next = ST_WAIT;
                                    end
                                    else if (status.out_free)
                                    begin
                                        // Bad closing byte, or the final pass closed.
                                        cmd.emit    = 1'b1;
                                        cmd.kind    = status.byte_zero ?
                                                      KIND_FINISH : KIND_ERROR;
                                        cmd.last    = 1'b1;
                                        cmd.restart = 1'b1;
                                        phase_next  = PH_CODE;
                                        state_next  = ST_WAIT;
                                    end
                                end
                                else
                                begin
                                    phase_next = PH_CLOSE1;
                                    state_next = ST_WAIT;
                                end
                            end
                            else
                            begin
                                // Plane A closed: a pending run or literal goes on in B.
                                cmd.next_pass = 1'b1;
                                if (status.rem_zero)
                                begin
                                    phase_next = PH_CODE;
                                    state_next = ST_WAIT;
                                end
                                else if (status.is_lit)
                                begin
                                    phase_next = PH_LITERAL;
                                    state_next = ST_WAIT;
                                end
                                else
                                begin
                                    phase_next = PH_CODE;
                                    state_next = ST_RUN;
                                end
                            end
                        end

                        default:
                        begin
                            cmd.restart = 1'b1;
                            phase_next  = PH_CODE;
                            state_next  = ST_WAIT;
                        end
                    endcase
                end
            end

            ST_RUN:
            begin
                if (status.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.kind    = KIND_SEGMENT;
                    cmd.seg_run = 1'b1;
                    cmd.last    = run_pass_end || status.rem_le_rows;
                    if (run_pass_end)
                    begin
                        phase_next = PH_CLOSE0;
                        state_next = ST_WAIT;
                    end
                    else if (status.rem_le_rows)
                    begin
                        state_next = ST_WAIT;
                    end
                end
            end

            default:
            begin
                state_next = ST_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_WAIT;
            phase_reg <= PH_CODE;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    assign stream_stall = (state_reg != ST_WAIT);

    `CRBD_ASSERT_IMPLY(a_emit_free, clk, rst_n, cmd.emit, status.out_free,
        "result issued while the output register is occupied")
    `CRBD_ASSERT_IMPLY(a_run_nonempty, clk, rst_n, state_reg == ST_RUN, !status.rem_zero,
        "run state with nothing left to write")
    `CRBD_ASSERT_NEXT(a_accept_exec, clk, rst_n, cmd.load_in, state_reg == ST_EXEC,
        "accepted item not followed by its execution step")

endmodule

/* hdl/column_rle_bitmap_decoder.sv */
`timescale 1ns / 1ps

// Column-major run-length bitmap decoder. Each accepted item is captured in the wait
// state and acted on in the execute state. A run value byte then enters the run state,
// which emits one write segment per cycle while the output register is free, since the
// single segment unit covers at most one column at a time. Results leave through an
// output register, so a new item is taken while a result waits on a stalled consumer; a
// step that must emit a result waits until that register is free. Configuration is to be
// written through cfg_write/cfg_index/cfg_data only while the decoder is idle; the user
// is bound to this, the block itself does not enforce it. Counters follow the new values
// at once only before the first byte of an image. There is no clearing pass after reset.
module column_rle_bitmap_decoder
    import crbd_pkg::*;
#(
    parameter int ROW_STRIDE  = 40,
    parameter int PLANE_BYTES = 8000
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data,
    input  logic                   stream_valid,
    output logic                   stream_stall,
    input  in_item_t               stream_item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output out_item_t              result_item
);

    cmd_t    cmd;
    status_t status;

    crbd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .stream_valid (stream_valid),
        .stream_stall (stream_stall),
        .cmd          (cmd),
        .status       (status)
    );

    crbd_datapath #(
        .ROW_STRIDE  (ROW_STRIDE),
        .PLANE_BYTES (PLANE_BYTES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .stream_item  (stream_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item),
        .cmd          (cmd),
        .status       (status)
    );

endmodule
